>>> hw/rtl/swmm_pkg.sv
// Shared types and constants for the sliding window max/min block.
package swmm_pkg;

    localparam int SAMPLE_W       = 32;
    localparam int CFG_W          = 7;
    localparam int POS_W_MIN      = 8;
    localparam int WINDOW_MAX_DEF = 64;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_TOP = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [CFG_W-1:0]           CFG_RESET  = CFG_W'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FRONT,
        ST_TAIL,
        ST_PUSH
    } swmm_state_t;

    // Result of one request as the sequencer hands it to the output stage.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] front;
        logic                       full;
        logic                       last;
    } swmm_result_t;

endpackage

>>> hw/rtl/sliding_window_max_min.sv
// Sliding window maximum with a running minimum of the full-window maxima.
//
// Input channel s_*: one signed sample per request, s_last_item on the final
// sample of a sequence. Result channel m_*: one result per request carrying the
// trailing window maximum, whether the window has filled, the running minimum
// of all full-window maxima and its valid flag; m_done_res echoes s_last_item.
// cfg_wr_en/cfg_wr_data set the window length (0 acts as 1, values above
// WINDOW_MAX act as WINDOW_MAX); write it only while the block is idle.
//
// A request reads the deque one entry at a time: it drops each expired entry at the
// head, reads the surviving head, and checks each tail entry against the sample,
// then pushes the sample. The candidate memory has a single read port; every
// sample is pushed once and dropped at most once. The result lands in the output
// register at the end of the push cycle, and s_ready returns in the next cycle
// even if that result is still held. If the receiver stalls with a result held,
// the next request runs up to its push step and waits there. Reset empties the deque,
// sets the window length to 1 and the running minimum to the largest signed value; the
// last sample of a sequence does the same to the stream state, leaving the window
// length as is.
module sliding_window_max_min #(
    parameter int WINDOW_MAX = swmm_pkg::WINDOW_MAX_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [swmm_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                                 s_last_item,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [swmm_pkg::SAMPLE_W-1:0] m_window_max,
    output logic                                 m_window_full,
    output logic signed [swmm_pkg::SAMPLE_W-1:0] m_min_of_maxima,
    output logic                                 m_min_valid,
    output logic                                 m_done_res,
    input  logic                                 cfg_wr_en,
    input  logic [swmm_pkg::CFG_W-1:0]           cfg_wr_data
);
    import swmm_pkg::*;

    localparam int AW     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
    localparam int POS_W  = (CNT_W > POS_W_MIN) ? CNT_W : POS_W_MIN;

    logic [CFG_W-1:0]           window_size_reg;
    logic                       res_valid;
    logic                       res_ready;
    swmm_result_t               res;
    logic                       ram_wr_en;
    logic [AW-1:0]              ram_wr_addr;
    logic signed [SAMPLE_W-1:0] ram_wr_value;
    logic [POS_W-1:0]           ram_wr_pos;
    logic [AW-1:0]              ram_rd_addr;
    logic signed [SAMPLE_W-1:0] ram_rd_value;
    logic [POS_W-1:0]           ram_rd_pos;

    logic                       m_valid_reg, m_valid_next;
    logic signed [SAMPLE_W-1:0] m_window_max_reg, m_window_max_next;
    logic                       m_window_full_reg, m_window_full_next;
    logic signed [SAMPLE_W-1:0] m_min_reg, m_min_next;
    logic                       m_min_valid_reg, m_min_valid_next;
    logic                       m_done_reg, m_done_next;
    logic signed [SAMPLE_W-1:0] run_min_reg, run_min_next;
    logic                       run_min_valid_reg, run_min_valid_next;
    logic signed [SAMPLE_W-1:0] min_upd;
    logic                       min_valid_upd;

    swmm_seq #(
        .WINDOW_MAX (WINDOW_MAX),
        .AW         (AW),
        .CNT_W      (CNT_W),
        .POS_W      (POS_W)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample     (s_sample),
        .s_last_item  (s_last_item),
        .window_size  (window_size_reg),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .ram_wr_en    (ram_wr_en),
        .ram_wr_addr  (ram_wr_addr),
        .ram_wr_value (ram_wr_value),
        .ram_wr_pos   (ram_wr_pos),
        .ram_rd_addr  (ram_rd_addr),
        .ram_rd_value (ram_rd_value),
        .ram_rd_pos   (ram_rd_pos)
    );

    swmm_cand_ram #(
        .DEPTH (WINDOW_MAX),
        .AW    (AW),
        .PW    (POS_W)
    ) u_ram (
        .aclk     (aclk),
        .wr_en    (ram_wr_en),
        .wr_addr  (ram_wr_addr),
        .wr_value (ram_wr_value),
        .wr_pos   (ram_wr_pos),
        .rd_addr  (ram_rd_addr),
        .rd_value (ram_rd_value),
        .rd_pos   (ram_rd_pos)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        if (res.full && (!run_min_valid_reg || res.front <= run_min_reg)) begin
            min_upd = res.front;
        end else begin
            min_upd = run_min_reg;
        end
        min_valid_upd = run_min_valid_reg || res.full;
    end

    always_comb begin
        m_valid_next       = m_valid_reg;
        m_window_max_next  = m_window_max_reg;
        m_window_full_next = m_window_full_reg;
        m_min_next         = m_min_reg;
        m_min_valid_next   = m_min_valid_reg;
        m_done_next        = m_done_reg;
        run_min_next       = run_min_reg;
        run_min_valid_next = run_min_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_valid_next       = 1'b1;
            m_window_max_next  = res.front;
            m_window_full_next = res.full;
            m_min_next         = min_upd;
            m_min_valid_next   = min_valid_upd;
            m_done_next        = res.last;
            if (res.last) begin
                run_min_next       = SAMPLE_TOP;
                run_min_valid_next = 1'b0;
            end else begin
                run_min_next       = min_upd;
                run_min_valid_next = min_valid_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_size_reg   <= CFG_RESET;
            m_valid_reg       <= 1'b0;
            run_min_reg       <= SAMPLE_TOP;
            run_min_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                window_size_reg <= cfg_wr_data;
            end
            m_valid_reg       <= m_valid_next;
            run_min_reg       <= run_min_next;
            run_min_valid_reg <= run_min_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_window_max_reg  <= m_window_max_next;
        m_window_full_reg <= m_window_full_next;
        m_min_reg         <= m_min_next;
        m_min_valid_reg   <= m_min_valid_next;
        m_done_reg        <= m_done_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_window_max    = m_window_max_reg;
    assign m_window_full   = m_window_full_reg;
    assign m_min_of_maxima = m_min_reg;
    assign m_min_valid     = m_min_valid_reg;
    assign m_done_res      = m_done_reg;

endmodule

>>> hw/rtl/swmm_cand_ram.sv
// Candidate storage of the deque: value and position per entry, one write and one read port.
module swmm_cand_ram #(
    parameter int DEPTH = swmm_pkg::WINDOW_MAX_DEF,
    parameter int AW    = 6,
    parameter int PW    = swmm_pkg::POS_W_MIN
) (
    input  logic                                 aclk,
    input  logic                                 wr_en,
    input  logic [AW-1:0]                        wr_addr,
    input  logic signed [swmm_pkg::SAMPLE_W-1:0] wr_value,
    input  logic [PW-1:0]                        wr_pos,
    input  logic [AW-1:0]                        rd_addr,
    output logic signed [swmm_pkg::SAMPLE_W-1:0] rd_value,
    output logic [PW-1:0]                        rd_pos
);
    import swmm_pkg::*;

    logic [SAMPLE_W-1:0] value_mem [DEPTH];
    logic [PW-1:0]       pos_mem   [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            value_mem[wr_addr] <= wr_value;
            pos_mem[wr_addr]   <= wr_pos;
        end
    end

    always_ff @(posedge aclk) begin
        rd_value <= value_mem[rd_addr];
        rd_pos   <= pos_mem[rd_addr];
    end

endmodule

>>> hw/rtl/swmm_seq.sv
// Deque sequencer: pops expired and dominated entries one per cycle, then pushes the sample.
module swmm_seq #(
    parameter int WINDOW_MAX = swmm_pkg::WINDOW_MAX_DEF,
    parameter int AW         = 6,
    parameter int CNT_W      = 7,
    parameter int POS_W      = swmm_pkg::POS_W_MIN
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [swmm_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                                 s_last_item,
    input  logic [swmm_pkg::CFG_W-1:0]           window_size,
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output swmm_pkg::swmm_result_t               res,
    output logic                                 ram_wr_en,
    output logic [AW-1:0]                        ram_wr_addr,
    output logic signed [swmm_pkg::SAMPLE_W-1:0] ram_wr_value,
    output logic [POS_W-1:0]                     ram_wr_pos,
    output logic [AW-1:0]                        ram_rd_addr,
    input  logic signed [swmm_pkg::SAMPLE_W-1:0] ram_rd_value,
    input  logic [POS_W-1:0]                     ram_rd_pos
);
    import swmm_pkg::*;

    swmm_state_t                state_reg, state_next;
    logic [AW-1:0]              head_reg, head_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [POS_W-1:0]           pos_reg, pos_next;
    logic                       seen_full_reg, seen_full_next;
    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;
    logic                       last_reg, last_next;
    logic [CNT_W-1:0]           k_reg, k_next;
    logic signed [SAMPLE_W-1:0] front_reg, front_next;

    logic [POS_W-1:0] age;
    logic             expired;
    logic             dominated;
    logic             reach_full;
    logic             fire;
    logic             deque_empty;

    // Ring address: base plus offset, wrapped once at the deque depth.
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                               input logic [CNT_W-1:0] off);
        logic [AW:0] sum;
        sum = (AW+1)'(base) + (AW+1)'(off);
        if (sum >= (AW+1)'(WINDOW_MAX)) begin
            sum = sum - (AW+1)'(WINDOW_MAX);
        end
        return sum[AW-1:0];
    endfunction

    assign age          = pos_reg - ram_rd_pos;
    assign expired      = age >= POS_W'(k_reg);
    assign dominated    = ram_rd_value <= sample_reg;
    assign reach_full   = ((POS_W+1)'(pos_reg) + (POS_W+1)'(1)) >= (POS_W+1)'(k_reg);
    assign deque_empty  = count_reg == '0;
    assign fire         = (state_reg == ST_PUSH) && res_ready;
    assign ram_wr_value = sample_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = deque_empty ? ST_PUSH : ST_FRONT;
                end
            end
            ST_FRONT: begin
                if (!expired) begin
                    state_next = ST_TAIL;
                end else if (count_reg == CNT_W'(1)) begin
                    state_next = ST_PUSH;
                end
            end
            ST_TAIL: begin
                if (!dominated || count_reg == CNT_W'(1)) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        head_next      = head_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        seen_full_next = seen_full_reg;
        sample_next    = sample_reg;
        last_next      = last_reg;
        k_next         = k_reg;
        front_next     = front_reg;
        ram_rd_addr    = head_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = ring_add(head_reg, count_reg);
        ram_wr_pos     = pos_reg;
        s_ready        = 1'b0;
        res_valid      = 1'b0;
        res.front      = deque_empty ? sample_reg : front_reg;
        res.full       = seen_full_reg || reach_full;
        res.last       = last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                sample_next = s_sample;
                last_next   = s_last_item;
                if (window_size == '0) begin
                    k_next = CNT_W'(1);
                end else if (32'(window_size) > 32'(WINDOW_MAX)) begin
                    k_next = CNT_W'(WINDOW_MAX);
                end else begin
                    k_next = CNT_W'(window_size);
                end
            end
            ST_FRONT: begin
                if (expired) begin
                    head_next   = ring_add(head_reg, CNT_W'(1));
                    count_next  = count_reg - CNT_W'(1);
                    ram_rd_addr = ring_add(head_reg, CNT_W'(1));
                end else begin
                    // Head survives; it stays the front unless tail pops empty the deque.
                    front_next  = ram_rd_value;
                    ram_rd_addr = ring_add(head_reg, count_reg - CNT_W'(1));
                end
            end
            ST_TAIL: begin
                if (dominated) begin
                    count_next  = count_reg - CNT_W'(1);
                    ram_rd_addr = ring_add(head_reg, count_reg - CNT_W'(2));
                end
            end
            ST_PUSH: begin
                res_valid = 1'b1;
                if (fire) begin
                    ram_wr_en = count_reg < CNT_W'(WINDOW_MAX);
                    if (last_reg) begin
                        head_next      = '0;
                        count_next     = '0;
                        pos_next       = '0;
                        seen_full_next = 1'b0;
                    end else begin
                        if (count_reg < CNT_W'(WINDOW_MAX)) begin
                            count_next = count_reg + CNT_W'(1);
                        end
                        pos_next       = pos_reg + POS_W'(1);
                        seen_full_next = seen_full_reg || reach_full;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            pos_reg       <= '0;
            seen_full_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            seen_full_reg <= seen_full_next;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg <= sample_next;
        last_reg   <= last_next;
        k_reg      <= k_next;
        front_reg  <= front_next;
    end

endmodule

>>> hw/rtl/swmm_checker.sv
// Port-level checks for the sliding window max/min block, bound to its top level.
module swmm_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_valid,
    input logic                                 s_ready,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic signed [swmm_pkg::SAMPLE_W-1:0] m_window_max,
    input logic                                 m_window_full,
    input logic signed [swmm_pkg::SAMPLE_W-1:0] m_min_of_maxima,
    input logic                                 m_min_valid,
    input logic                                 m_done_res
);
    import swmm_pkg::*;

    // A held result keeps its window maximum, running minimum and done flag until the receiver takes it.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_window_max)
            && $stable(m_min_of_maxima) && $stable(m_done_res))
        else $error("result changed while stalled");

    // Without a completed window the running minimum is still at its reset value.
    a_min_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_min_valid |-> m_min_of_maxima == SAMPLE_TOP)
        else $error("running minimum moved before any full window");

    // A full window always contributes to the running minimum.
    a_full_min: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_window_full |-> m_min_valid
            && m_min_of_maxima <= m_window_max)
        else $error("running minimum above the current full-window maximum");

    // Each request keeps the sequencer busy, so s_ready drops after an acceptance.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("new request taken right after another");

endmodule

bind sliding_window_max_min swmm_checker u_swmm_checker (.*);

>>> tb/sv/tb_sliding_window_max_min.sv
// Self-checking testbench for the sliding window max/min block.
module tb_sliding_window_max_min;
    timeunit 1ns;
    timeprecision 1ps;

    import swmm_pkg::*;

    localparam int WIN_DEPTH = WINDOW_MAX_DEF;

    // Tracks the deque and running minimum and holds the results still owed by the block.
    class window_extreme_tracker;
        typedef struct {
            logic signed [SAMPLE_W-1:0] wmax;
            logic                       full;
            logic signed [SAMPLE_W-1:0] mmin;
            logic                       mvalid;
            logic                       done;
        } extreme_t;

        extreme_t                   owed_extremes[$];
        logic signed [SAMPLE_W-1:0] cand_val[WIN_DEPTH];
        bit [7:0]                   cand_pos[WIN_DEPTH];
        int                         head;
        int                         count;
        bit [7:0]                   pos;
        bit                         seen_full;
        logic signed [SAMPLE_W-1:0] run_min;
        bit                         run_min_valid;
        bit [CFG_W-1:0]             win_len;
        int                         errors;

        function new();
            win_len = CFG_RESET;
            errors  = 0;
            clear_stream();
        endfunction

        function void clear_stream();
            head          = 0;
            count         = 0;
            pos           = 0;
            seen_full     = 0;
            run_min       = SAMPLE_TOP;
            run_min_valid = 0;
        endfunction

        function void set_window(bit [CFG_W-1:0] v);
            win_len = v;
        endfunction

        function int pending();
            return owed_extremes.size();
        endfunction

        function void note_sample(logic signed [SAMPLE_W-1:0] smp, bit last);
            int       k;
            int       tail;
            int       slot;
            bit [7:0] age;
            extreme_t r;
            k = int'(win_len);
            if (k < 1) k = 1;
            if (k > WIN_DEPTH) k = WIN_DEPTH;
            // Ages are taken mod 256 so they stay exact across the position wrap.
            while (count > 0) begin
                age = pos - cand_pos[head];
                if (age < k) break;
                head  = (head + 1) % WIN_DEPTH;
                count = count - 1;
            end
            while (count > 0) begin
                tail = (head + count - 1) % WIN_DEPTH;
                if (cand_val[tail] > smp) break;
                count = count - 1;
            end
            if (count < WIN_DEPTH) begin
                slot           = (head + count) % WIN_DEPTH;
                cand_val[slot] = smp;
                cand_pos[slot] = pos;
                count          = count + 1;
            end
            if (int'(pos) + 1 >= k) seen_full = 1;
            pos = pos + 8'd1;
            if (seen_full) begin
                if (!run_min_valid || cand_val[head] <= run_min) run_min = cand_val[head];
                run_min_valid = 1;
            end
            r.wmax   = cand_val[head];
            r.full   = seen_full;
            r.mmin   = run_min;
            r.mvalid = run_min_valid;
            r.done   = last;
            owed_extremes.insert(owed_extremes.size(), r);
            if (last) clear_stream();
        endfunction

        task report(string what, logic [SAMPLE_W-1:0] got, logic [SAMPLE_W-1:0] want);
            $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
            errors = errors + 1;
        endtask

        task check_extremes(logic signed [SAMPLE_W-1:0] wmax, logic full,
                            logic signed [SAMPLE_W-1:0] mmin, logic mvalid, logic done);
            extreme_t e;
            if (owed_extremes.size() == 0) begin
                report("result with no request outstanding", wmax, 'x);
            end else begin
                e = owed_extremes[0];
                owed_extremes.delete(0);
                if (wmax !== e.wmax) report("window_max", wmax, e.wmax);
                if (full !== e.full)
                    report("window_full", SAMPLE_W'(full), SAMPLE_W'(e.full));
                if (mmin !== e.mmin) report("min_of_maxima", mmin, e.mmin);
                if (mvalid !== e.mvalid)
                    report("min_valid", SAMPLE_W'(mvalid), SAMPLE_W'(e.mvalid));
                if (done !== e.done)
                    report("done_res", SAMPLE_W'(done), SAMPLE_W'(e.done));
            end
        endtask
    endclass

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_sample;
    logic                       s_last_item;
    logic                       m_valid;
    logic                       m_ready;
    logic signed [SAMPLE_W-1:0] m_window_max;
    logic                       m_window_full;
    logic signed [SAMPLE_W-1:0] m_min_of_maxima;
    logic                       m_min_valid;
    logic                       m_done_res;
    logic                       cfg_wr_en;
    logic [CFG_W-1:0]           cfg_wr_data;

    window_extreme_tracker      tracker = new();
    int                         send_idle;
    int                         recv_idle;
    logic signed [SAMPLE_W-1:0] trend_val;

    sliding_window_max_min DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample        (s_sample),
        .s_last_item     (s_last_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_window_max    (m_window_max),
        .m_window_full   (m_window_full),
        .m_min_of_maxima (m_min_of_maxima),
        .m_min_valid     (m_min_valid),
        .m_done_res      (m_done_res),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    // Receiver: ready is redrawn every cycle at the falling edge.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready = ($urandom_range(0, 99) >= recv_idle);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.check_extremes(m_window_max, m_window_full, m_min_of_maxima,
                                   m_min_valid, m_done_res);
    end

    // Called just after a falling edge; returns just after the falling edge that
    // follows acceptance, with s_valid still high.
    task push_sample(logic signed [SAMPLE_W-1:0] smp, bit last);
        while ($urandom_range(0, 99) < send_idle) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid     = 1'b1;
        s_sample    = smp;
        s_last_item = last;
        do @(posedge aclk); while (!s_ready);
        tracker.note_sample(smp, last);
        @(negedge aclk);
    endtask

    task wait_results_done();
        s_valid = 1'b0;
        while (tracker.pending() != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task set_window_length(bit [CFG_W-1:0] v);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        tracker.set_window(v);
    endtask

    function bit [CFG_W-1:0] pick_window();
        case ($urandom_range(0, 9))
            0: return CFG_W'(0);
            1: return CFG_W'(1);
            2: return CFG_W'(WIN_DEPTH);
            3: return CFG_W'($urandom_range(WIN_DEPTH + 1, (1 << CFG_W) - 1));
            4: return CFG_W'(2);
            5: return CFG_W'($urandom_range(1, WIN_DEPTH));
            default: return CFG_W'($urandom_range(1, 8));
        endcase
    endfunction

    function logic signed [SAMPLE_W-1:0] pick_sample(int mode);
        int m;
        m = (mode == 5) ? $urandom_range(0, 4) : mode;
        case (m)
            0: return $urandom;
            1: begin
                case ($urandom_range(0, 4))
                    0: return SAMPLE_TOP;
                    1: return ~SAMPLE_TOP;
                    2: return -1;
                    3: return 0;
                    default: return 1;
                endcase
            end
            2: return int'($urandom_range(0, 8)) - 4;
            // Trends build a long deque (descending) or keep emptying it (ascending).
            3: begin
                trend_val = trend_val - $urandom_range(0, 3);
                return trend_val;
            end
            default: begin
                trend_val = trend_val + $urandom_range(0, 3);
                return trend_val;
            end
        endcase
    endfunction

    task run_sequence(int len, int mode);
        trend_val = $urandom;
        for (int i = 0; i < len; i++) begin
            // Occasionally change the window length in the middle of a sequence.
            if (i > 0 && $urandom_range(0, 15) == 0) begin
                wait_results_done();
                set_window_length(pick_window());
            end
            push_sample(pick_sample(mode), i == len - 1);
        end
    endtask

    task run_random_phase(int n_items, int s_idle, int r_idle);
        int sent;
        int k;
        int len;
        send_idle = s_idle;
        recv_idle = r_idle;
        sent      = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 2) == 0) begin
                wait_results_done();
                set_window_length(pick_window());
            end
            k = int'(tracker.win_len);
            if (k < 1) k = 1;
            if (k > WIN_DEPTH) k = WIN_DEPTH;
            len = $urandom_range(1, k + 6);
            run_sequence(len, $urandom_range(0, 5));
            sent = sent + len;
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_sample    = '0;
        s_last_item = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        send_idle   = 19;
        recv_idle   = 73;
        trend_val   = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Window length at its reset value, extreme samples.
        push_sample(SAMPLE_TOP, 1'b0);
        push_sample(~SAMPLE_TOP, 1'b1);

        // Equal samples must replace each other in the deque.
        wait_results_done();
        set_window_length(3);
        push_sample(5, 1'b0);
        push_sample(5, 1'b0);
        push_sample(5, 1'b0);
        push_sample(-7, 1'b0);
        push_sample(10, 1'b0);
        push_sample(~SAMPLE_TOP, 1'b0);
        push_sample(0, 1'b1);

        // Sequence ends before the window fills.
        wait_results_done();
        set_window_length(4);
        push_sample(1, 1'b0);
        push_sample(2, 1'b1);

        // Zero acts as one, oversized values act as the full depth.
        wait_results_done();
        set_window_length(0);
        push_sample(3, 1'b0);
        push_sample(-1, 1'b0);
        push_sample(4, 1'b1);
        wait_results_done();
        set_window_length(CFG_W'((1 << CFG_W) - 1));
        push_sample(-3, 1'b0);
        push_sample(8, 1'b0);
        push_sample(-9, 1'b0);
        push_sample(2, 1'b1);

        // Window length changed with a sequence in progress.
        wait_results_done();
        set_window_length(2);
        push_sample(9, 1'b0);
        push_sample(1, 1'b0);
        push_sample(8, 1'b0);
        wait_results_done();
        set_window_length(5);
        push_sample(2, 1'b0);
        push_sample(3, 1'b1);

        run_random_phase(50, 19, 73);
        run_random_phase(50, 73, 19);

        // No idling; one sequence long enough to wrap the position counter.
        send_idle = 0;
        recv_idle = 0;
        wait_results_done();
        set_window_length(CFG_W'(WIN_DEPTH));
        run_sequence(270, 5);
        run_random_phase(10, 0, 0);

        wait_results_done();
        repeat (20) @(negedge aclk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
